[design/rwlf_pkg.sv]
// ----------------------------------------------------------------------------
// RGB waypoint line fader package
// Shared widths, types, reset colors and the goal index step function.
// ----------------------------------------------------------------------------
package rwlf_pkg;

   localparam int CHANNEL_BITS   = 8;
   localparam int COLOR_BITS     = 3 * CHANNEL_BITS;
   localparam int NUM_WAYPOINTS  = 6;
   localparam int INDEX_BITS     = 3;
   localparam int CSR_INDEX_BITS = 3;

   typedef logic [CHANNEL_BITS-1:0]   chan_type;
   typedef logic [COLOR_BITS-1:0]     color_type;
   typedef logic [INDEX_BITS-1:0]     index_type;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam index_type FIRST_INDEX = 3'd0;
   localparam index_type START_INDEX = 3'd1;
   localparam index_type LAST_INDEX  = 3'd5;

   localparam chan_type CH_ZERO = '0;
   localparam chan_type CH_FULL = '1;

   // black, green, yellow, red, blue, white
   localparam color_type WP_RESET [NUM_WAYPOINTS] = '{
      {CH_ZERO, CH_ZERO, CH_ZERO},
      {CH_ZERO, CH_FULL, CH_ZERO},
      {CH_FULL, CH_FULL, CH_ZERO},
      {CH_FULL, CH_ZERO, CH_ZERO},
      {CH_ZERO, CH_ZERO, CH_FULL},
      {CH_FULL, CH_FULL, CH_FULL}
   };

   typedef struct packed {
      index_type index;
      logic      hold;
   } goal_type;

   // Step the index one place, saturating to the waypoint range.
   function automatic index_type move_index(index_type idx, logic fwd);
      index_type r;
      if (fwd) begin
         r = (idx >= LAST_INDEX) ? LAST_INDEX : idx + index_type'(1);
      end else begin
         r = (idx == FIRST_INDEX) ? FIRST_INDEX : idx - index_type'(1);
      end
      return r;
   endfunction

   // True when two channel values differ by at most one.
   function automatic logic chan_near(chan_type a, chan_type b);
      logic [CHANNEL_BITS:0] ax;
      logic [CHANNEL_BITS:0] bx;
      ax = {1'b0, a};
      bx = {1'b0, b};
      return (ax == bx) || (ax == bx + 1'b1) || (bx == ax + 1'b1);
   endfunction

endpackage

[design/rwlf_if.sv]
// ----------------------------------------------------------------------------
// RGB waypoint line fader channels
// Valid/ready channels for tick requests, color responses and register writes.
// ----------------------------------------------------------------------------
interface rwlf_req_if import rwlf_pkg::*; ();
   logic valid;
   logic ready;
   logic forward;
   modport source (output valid, output forward, input ready);
   modport sink   (input valid, input forward, output ready);
endinterface

interface rwlf_rsp_if import rwlf_pkg::*; ();
   logic     valid;
   logic     ready;
   chan_type red;
   chan_type green;
   chan_type blue;
   modport source (output valid, output red, output green, output blue, input ready);
   modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

interface rwlf_csr_if import rwlf_pkg::*; ();
   logic          valid;
   logic          ready;
   csr_index_type index;
   color_type     data;
   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[design/rwlf_regs.sv]
// ----------------------------------------------------------------------------
// RGB waypoint line fader registers
// Holds the six waypoint colors; writes beyond the list are dropped.
// ----------------------------------------------------------------------------
module rwlf_regs import rwlf_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   rwlf_csr_if.sink   csr,
   output color_type  waypoint [NUM_WAYPOINTS]
);

   color_type wp_ff [NUM_WAYPOINTS];
   color_type wp_in [NUM_WAYPOINTS];

   assign csr.ready = 1'b1;

   always_comb begin
      wp_in = wp_ff;
      for (int i = 0; i < NUM_WAYPOINTS; i++) begin
         if (csr.valid && (csr.index == CSR_INDEX_BITS'(i))) begin
            wp_in[i] = csr.data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= WP_RESET;
      end else begin
         wp_ff <= wp_in;
      end
   end

   assign waypoint = wp_ff;

endmodule

[design/rwlf_goal.sv]
// ----------------------------------------------------------------------------
// RGB waypoint line fader goal selection
// Picks the goal waypoint for this tick, or flags a hold at an end waypoint.
// ----------------------------------------------------------------------------
module rwlf_goal import rwlf_pkg::*; (
   input  color_type present,
   input  color_type waypoint [NUM_WAYPOINTS],
   input  index_type goal_index,
   input  logic      prev_fwd,
   input  logic      forward,
   output goal_type  goal
);

   logic [NUM_WAYPOINTS-1:0] at_wp;
   index_type                cur;
   index_type                step1;

   always_comb begin
      for (int i = 0; i < NUM_WAYPOINTS; i++) begin
         at_wp[i] = (present == waypoint[i]);
      end
   end

   assign cur   = (goal_index > LAST_INDEX) ? LAST_INDEX : goal_index;
   assign step1 = move_index(cur, forward);

   always_comb begin
      goal.index = cur;
      goal.hold  = 1'b0;
      if (at_wp[cur]) begin
         // end waypoints only turn inward
         priority if (cur == FIRST_INDEX) begin
            if (forward) goal.index = step1;
            else         goal.hold  = 1'b1;
         end else if (cur == LAST_INDEX) begin
            if (!forward) goal.index = step1;
            else          goal.hold  = 1'b1;
         end else begin
            goal.index = step1;
         end
      end else if (forward != prev_fwd) begin
         // retarget; skip a waypoint the color already sits on
         goal.index = at_wp[step1] ? move_index(step1, forward) : step1;
      end
   end

endmodule

[design/rwlf_line.sv]
// ----------------------------------------------------------------------------
// RGB waypoint line fader line step
// One 3D line step from the present color toward the target color.
// ----------------------------------------------------------------------------
module rwlf_line import rwlf_pkg::*; (
   input  color_type present,
   input  color_type target,
   output color_type next
);

   chan_type   pos   [3];
   chan_type   goal  [3];
   chan_type   mag   [3];
   logic [2:0] up;
   logic [2:0] moves;
   chan_type   nxt   [3];
   logic [1:0] dom;
   chan_type   mag_dom;

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         pos[k]  = present[COLOR_BITS-1-k*CHANNEL_BITS -: CHANNEL_BITS];
         goal[k] = target[COLOR_BITS-1-k*CHANNEL_BITS -: CHANNEL_BITS];
         up[k]   = goal[k] > pos[k];
         mag[k]  = up[k] ? goal[k] - pos[k] : pos[k] - goal[k];
      end
   end

   // ties go to red, then green
   always_comb begin
      priority if ((mag[0] >= mag[1]) && (mag[0] >= mag[2])) dom = 2'd0;
      else if (mag[1] >= mag[2])                            dom = 2'd1;
      else                                                  dom = 2'd2;
   end

   assign mag_dom = mag[dom];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         if (dom == 2'(k)) begin
            moves[k] = (mag_dom != CH_ZERO);
         end else begin
            moves[k] = (mag_dom != CH_ZERO) && ({mag[k], 1'b0} >= {1'b0, mag_dom});
         end
         nxt[k] = moves[k] ? (up[k] ? pos[k] + 1'b1 : pos[k] - 1'b1) : pos[k];
      end
   end

   assign next = {nxt[0], nxt[1], nxt[2]};

endmodule

[design/rgb_waypoint_line_fader_top.sv]
// A tick passes the input register, then its color step is loaded
// into the output register. Throughput: one tick per cycle while the
// response channel does not stall; the fade state updates as a tick
// leaves the input register, so each tick sees the color left by the
// one before. Reset clears both valid flags, sets the color to black, the
// goal to waypoint 1, the direction to forward, waypoints to their defaults.
// ----------------------------------------------------------------------------
// RGB waypoint line fader top level
// Fades a color through six waypoint colors, at most one line step per tick.
// ----------------------------------------------------------------------------
module rgb_waypoint_line_fader_top import rwlf_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   rwlf_req_if.sink    req_chan,
   rwlf_rsp_if.source  rsp_chan,
   rwlf_csr_if.sink    csr_chan
);

   color_type waypoint [NUM_WAYPOINTS];
   goal_type  goal;
   color_type line_color;
   color_type step_color;

   logic      in_valid_ff,  in_valid_in;
   logic      in_fwd_ff,    in_fwd_in;
   logic      rsp_valid_ff, rsp_valid_in;
   color_type rsp_color_ff, rsp_color_in;
   color_type present_ff,   present_in;
   index_type goal_index_ff, goal_index_in;
   logic      prev_fwd_ff,  prev_fwd_in;

   logic      out_take;
   logic      step;

   rwlf_regs u_regs (
      .clock    (clock),
      .reset    (reset),
      .csr      (csr_chan),
      .waypoint (waypoint)
   );

   rwlf_goal u_goal (
      .present    (present_ff),
      .waypoint   (waypoint),
      .goal_index (goal_index_ff),
      .prev_fwd   (prev_fwd_ff),
      .forward    (in_fwd_ff),
      .goal       (goal)
   );

   rwlf_line u_line (
      .present (present_ff),
      .target  (waypoint[goal.index]),
      .next    (line_color)
   );

   assign out_take       = !rsp_valid_ff || rsp_chan.ready;
   assign step           = in_valid_ff && out_take;
   assign req_chan.ready = !in_valid_ff || out_take;
   assign step_color     = goal.hold ? present_ff : line_color;

   always_comb begin
      in_valid_in   = in_valid_ff;
      in_fwd_in     = in_fwd_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_color_in  = rsp_color_ff;
      present_in    = present_ff;
      goal_index_in = goal_index_ff;
      prev_fwd_in   = prev_fwd_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
         in_fwd_in   = req_chan.forward;
      end
      if (out_take) begin
         rsp_valid_in = in_valid_ff;
      end
      if (step) begin
         rsp_color_in  = step_color;
         present_in    = step_color;
         goal_index_in = goal.index;
         if (!goal.hold) prev_fwd_in = in_fwd_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         present_ff    <= '0;
         goal_index_ff <= START_INDEX;
         prev_fwd_ff   <= 1'b1;
      end else begin
         in_valid_ff   <= in_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         present_ff    <= present_in;
         goal_index_ff <= goal_index_in;
         prev_fwd_ff   <= prev_fwd_in;
      end
   end

   always_ff @(posedge clock) begin
      in_fwd_ff    <= in_fwd_in;
      rsp_color_ff <= rsp_color_in;
   end

   assign rsp_chan.valid = rsp_valid_ff;
   assign rsp_chan.red   = rsp_color_ff[COLOR_BITS-1 -: CHANNEL_BITS];
   assign rsp_chan.green = rsp_color_ff[2*CHANNEL_BITS-1 -: CHANNEL_BITS];
   assign rsp_chan.blue  = rsp_color_ff[CHANNEL_BITS-1:0];

endmodule

[design/rwlf_checker.sv]
// ----------------------------------------------------------------------------
// RGB waypoint line fader checker
// Port-level checks on the response channel, bound to the top level.
// ----------------------------------------------------------------------------
module rwlf_checker import rwlf_pkg::*; (
   input logic     clock,
   input logic     reset,
   input logic     req_valid,
   input logic     req_ready,
   input logic     rsp_valid,
   input logic     rsp_ready,
   input chan_type rsp_red,
   input chan_type rsp_green,
   input chan_type rsp_blue
);

   chan_type last_red_ff,   last_red_in;
   chan_type last_green_ff, last_green_in;
   chan_type last_blue_ff,  last_blue_in;
   logic     rsp_fire;
   logic     near_last;

   assign rsp_fire  = rsp_valid && rsp_ready;
   assign near_last = chan_near(rsp_red, last_red_ff) && chan_near(rsp_green, last_green_ff)
                      && chan_near(rsp_blue, last_blue_ff);

   always_comb begin
      last_red_in   = last_red_ff;
      last_green_in = last_green_ff;
      last_blue_in  = last_blue_ff;
      if (rsp_fire) begin
         last_red_in   = rsp_red;
         last_green_in = rsp_green;
         last_blue_in  = rsp_blue;
      end
   end

   // color starts black after reset
   always_ff @(posedge clock) begin
      if (reset) begin
         last_red_ff   <= '0;
         last_green_ff <= '0;
         last_blue_ff  <= '0;
      end else begin
         last_red_ff   <= last_red_in;
         last_green_ff <= last_green_in;
         last_blue_ff  <= last_blue_in;
      end
   end

   a_rsp_valid_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response valid dropped while stalled");

   a_rsp_payload_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable({rsp_red, rsp_green, rsp_blue}))
      else $error("response payload changed while stalled");

   a_rsp_from_req: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && req_ready, 2))
      else $error("response appeared without a tick two cycles earlier");

   a_step_size: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> near_last)
      else $error("color moved by more than one step in a channel");

endmodule

bind rgb_waypoint_line_fader_top rwlf_checker u_rwlf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_chan.valid),
   .req_ready (req_chan.ready),
   .rsp_valid (rsp_chan.valid),
   .rsp_ready (rsp_chan.ready),
   .rsp_red   (rsp_chan.red),
   .rsp_green (rsp_chan.green),
   .rsp_blue  (rsp_chan.blue)
);
